FILE: hw/rtl/uvs_pkg.sv
`default_nettype none

package uvs_pkg;

    localparam int ELEM_W = 17;
    localparam int FIELD_W = 16;
    localparam int ANG_W = 32;
    localparam int CORD_W = 32;
    localparam int ATAN_DEPTH = 24;

    localparam logic CMD_VERTEX = 1'b0;

    localparam logic REG_SLICES = 1'b0;
    localparam logic REG_STACKS = 1'b1;

    localparam logic [2:0] KIND_BAD  = 3'd0;
    localparam logic [2:0] KIND_TOP  = 3'd1;
    localparam logic [2:0] KIND_BOT  = 3'd2;
    localparam logic [2:0] KIND_VERT = 3'd3;
    localparam logic [2:0] KIND_CAP  = 3'd4;
    localparam logic [2:0] KIND_BODY = 3'd5;

    localparam logic [FIELD_W-1:0] POS_ONE = 16'h4000;
    localparam logic [FIELD_W-1:0] POS_MINUS_ONE = 16'hC000;
    localparam logic [FIELD_W-1:0] TEX_ONE = 16'h8000;

    localparam logic signed [CORD_W-1:0] CORDIC_X0 = 32'sd652032874;
    localparam logic [ANG_W-1:0] EIGHTH_TURN = 32'h2000_0000;
    localparam logic signed [63:0] ROUND_46 = 64'sh0000_2000_0000_0000;
    localparam logic signed [63:0] ROUND_16 = 64'sh0000_0000_0000_8000;

    localparam logic [ANG_W-1:0] ATAN_TURNS [ATAN_DEPTH] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};

    typedef struct packed {
        logic               valid;
        logic [2:0]         kind;
        logic               odd;
        logic [ELEM_W-1:0]  dividend;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] c;
    } pre_t;

    typedef struct packed {
        logic               valid;
        logic [2:0]         kind;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] c;
    } post_t;

    typedef struct packed {
        post_t              post;
        logic [FIELD_W-1:0] tex_u;
        logic [FIELD_W-1:0] tex_v;
    } late_t;

    function automatic logic [FIELD_W-1:0] sat_q14(input logic signed [63:0] v);
        logic [FIELD_W-1:0] res;
        if (v > 64'sd16384)
        begin
            res = POS_ONE;
        end
        else if (v < -64'sd16384)
        begin
            res = POS_MINUS_ONE;
        end
        else
        begin
            res = v[FIELD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/uvs_delay.sv
`default_nettype none

module uvs_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] d,
    output logic      [WIDTH-1:0] q
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

`default_nettype wire

FILE: hw/rtl/uvs_div_cell.sv
`default_nettype none

module uvs_div_cell #(
    parameter int DW = 8,
    parameter int QW = 8
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [DW+QW-1:0] w_in,
    input  wire logic [DW-1:0]    den_in,
    output logic      [DW+QW-1:0] w_out,
    output logic      [DW-1:0]    den_out
);

    logic [DW:0]       trial;
    logic              fits;
    logic [DW:0]       diff;
    logic [DW-1:0]     rem_next;
    logic [DW+QW-1:0]  w_reg;
    logic [DW-1:0]     den_reg;

    always_comb
    begin
        trial = {w_in[DW+QW-1:QW], w_in[QW-1]};
        fits = (trial >= {1'b0, den_in});
        diff = trial - {1'b0, den_in};
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg <= {rem_next, w_in[QW-2:0], fits};
            den_reg <= den_in;
        end
    end

    assign w_out = w_reg;
    assign den_out = den_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/uvs_divider.sv
`default_nettype none

module uvs_divider #(
    parameter int DW = 8,
    parameter int QW = 8
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [DW+QW-1:0] num,
    input  wire logic [DW-1:0]    den,
    output logic      [QW-1:0]    quot,
    output logic      [DW-1:0]    rem
);

    logic [DW+QW-1:0] w_chain [QW+1];
    logic [DW-1:0]    d_chain [QW+1];

    assign w_chain[0] = num;
    assign d_chain[0] = den;

    for (genvar k = 0; k < QW; k++)
    begin : g_cell
        uvs_div_cell #(
            .DW(DW),
            .QW(QW)
        ) u_cell (
            .clk    (clk),
            .en     (en),
            .w_in   (w_chain[k]),
            .den_in (d_chain[k]),
            .w_out  (w_chain[k+1]),
            .den_out(d_chain[k+1])
        );
    end

    assign quot = w_chain[QW][QW-1:0];
    assign rem = w_chain[QW][DW+QW-1:QW];

endmodule

`default_nettype wire

FILE: hw/rtl/uvs_cordic_cell.sv
`default_nettype none

module uvs_cordic_cell #(
    parameter int K = 0
) (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [uvs_pkg::CORD_W-1:0]  x_in,
    input  wire logic signed [uvs_pkg::CORD_W-1:0]  y_in,
    input  wire logic signed [uvs_pkg::CORD_W-1:0]  z_in,
    input  wire logic        [1:0]                  quad_in,
    output logic signed      [uvs_pkg::CORD_W-1:0]  x_out,
    output logic signed      [uvs_pkg::CORD_W-1:0]  y_out,
    output logic signed      [uvs_pkg::CORD_W-1:0]  z_out,
    output logic             [1:0]                  quad_out
);

    logic signed [uvs_pkg::CORD_W-1:0] dx;
    logic signed [uvs_pkg::CORD_W-1:0] dy;
    logic signed [uvs_pkg::CORD_W-1:0] step;
    logic signed [uvs_pkg::CORD_W-1:0] x_next;
    logic signed [uvs_pkg::CORD_W-1:0] y_next;
    logic signed [uvs_pkg::CORD_W-1:0] z_next;
    logic signed [uvs_pkg::CORD_W-1:0] x_reg;
    logic signed [uvs_pkg::CORD_W-1:0] y_reg;
    logic signed [uvs_pkg::CORD_W-1:0] z_reg;
    logic        [1:0]                 quad_reg;

    always_comb
    begin
        dx = y_in >>> K;
        dy = x_in >>> K;
        step = signed'(uvs_pkg::ATAN_TURNS[K]);
        if (!z_in[uvs_pkg::CORD_W-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - step;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            quad_reg <= quad_in;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign quad_out = quad_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/uvs_cordic.sv
`default_nettype none

module uvs_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic        [uvs_pkg::ANG_W-1:0]  angle,
    output logic signed      [uvs_pkg::CORD_W-1:0] cos_out,
    output logic signed      [uvs_pkg::CORD_W-1:0] sin_out
);

    logic        [uvs_pkg::ANG_W-1:0]  shifted;
    logic signed [uvs_pkg::CORD_W-1:0] x_chain [STEPS+1];
    logic signed [uvs_pkg::CORD_W-1:0] y_chain [STEPS+1];
    logic signed [uvs_pkg::CORD_W-1:0] z_chain [STEPS+1];
    logic        [1:0]                 q_chain [STEPS+1];
    logic signed [uvs_pkg::CORD_W-1:0] z_reg;
    logic        [1:0]                 quad_reg;
    logic signed [uvs_pkg::CORD_W-1:0] xf;
    logic signed [uvs_pkg::CORD_W-1:0] yf;

    assign shifted = angle + uvs_pkg::EIGHTH_TURN;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg <= shifted[31:30];
            z_reg <= signed'({2'b00, shifted[29:0]}) - signed'(uvs_pkg::EIGHTH_TURN);
        end
    end

    assign x_chain[0] = uvs_pkg::CORDIC_X0;
    assign y_chain[0] = '0;
    assign z_chain[0] = z_reg;
    assign q_chain[0] = quad_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        uvs_cordic_cell #(
            .K(k)
        ) u_cell (
            .clk     (clk),
            .en      (en),
            .x_in    (x_chain[k]),
            .y_in    (y_chain[k]),
            .z_in    (z_chain[k]),
            .quad_in (q_chain[k]),
            .x_out   (x_chain[k+1]),
            .y_out   (y_chain[k+1]),
            .z_out   (z_chain[k+1]),
            .quad_out(q_chain[k+1])
        );
    end

    assign xf = x_chain[STEPS];
    assign yf = y_chain[STEPS];

    always_comb
    begin
        case (q_chain[STEPS])
            2'd0:
            begin
                cos_out = xf;
                sin_out = yf;
            end
            2'd1:
            begin
                cos_out = -yf;
                sin_out = xf;
            end
            2'd2:
            begin
                cos_out = -xf;
                sin_out = -yf;
            end
            default:
            begin
                cos_out = yf;
                sin_out = -xf;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/uv_sphere_mesh_generator_top.sv
// One request is accepted in every cycle unless a pending response is stalled; the chains of
// divider and CORDIC cells are fully pipelined and hold one request per cell.
// The whole pipeline advances together and holds while a response is stalled.
// Reset sets slices and stacks to 16 and empties the pipeline.
`default_nettype none

module uv_sphere_mesh_generator_top #(
    parameter int MAX_SLICES = 256,
    parameter int MAX_STACKS = 256,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic        command,
    input  wire logic [16:0] element,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic      [15:0] pos_x,
    output logic      [15:0] pos_y,
    output logic      [15:0] pos_z,
    output logic      [15:0] tex_u,
    output logic      [15:0] tex_v,
    output logic      [15:0] corner_a,
    output logic      [15:0] corner_b,
    output logic      [15:0] corner_c,
    output logic             bad_index
);

    localparam int NS_W = $clog2(MAX_SLICES + 1);
    localparam int NK_W = $clog2(MAX_STACKS + 1);
    localparam int CNT_W = (NS_W + NK_W + 1 > 17) ? NS_W + NK_W + 2 : 18;
    localparam int NS_RST = (MAX_SLICES < 16) ? MAX_SLICES : 16;
    localparam int NK_RST = (MAX_STACKS < 16) ? MAX_STACKS : 16;
    localparam int M1_RST = NS_RST * (NK_RST - 1);
    localparam int M2_RST = NS_RST * (NK_RST - 2);
    localparam int PH_W = NK_W + 1 + uvs_pkg::ANG_W;
    localparam int TH_W = NS_W + 1 + uvs_pkg::ANG_W;

    logic              adv;
    logic [8:0]        slices_reg;
    logic [8:0]        stacks_reg;
    logic [NS_W-1:0]   ns_next;
    logic [NK_W-1:0]   nk_next;
    logic [NS_W-1:0]   ns_reg;
    logic [NK_W-1:0]   nk_reg;
    logic [CNT_W-1:0]  m1;
    logic [CNT_W-1:0]  m2;
    logic [CNT_W-1:0]  nverts_reg;
    logic [CNT_W-1:0]  ntris_reg;
    logic [CNT_W-1:0]  body_reg;
    logic [CNT_W-1:0]  last_reg;

    logic                      v1_reg;
    logic                      cmd1_reg;
    logic [uvs_pkg::ELEM_W-1:0] e1_reg;

    logic [CNT_W-1:0] e_x;
    logic [CNT_W-1:0] ns_x;
    logic [CNT_W-1:0] t_x;
    logic [CNT_W-1:0] i_x;
    logic [CNT_W-1:0] cap_c;
    logic [CNT_W-1:0] bot_n;
    uvs_pkg::pre_t    pre_next;
    uvs_pkg::pre_t    pre_reg;
    uvs_pkg::pre_t    pre_d;

    logic [uvs_pkg::ELEM_W-1:0] d1_quot;
    logic [NS_W-1:0]            d1_rem;

    logic [CNT_W-1:0] quad;
    logic [CNT_W-1:0] i_b;
    logic [CNT_W-1:0] row0;
    logic [CNT_W-1:0] row1;
    logic [CNT_W-1:0] nxt_b;
    uvs_pkg::post_t   post_next;
    uvs_pkg::post_t   post_reg;
    uvs_pkg::post_t   post_d;
    logic [NK_W-1:0]  r_reg;
    logic [NS_W-1:0]  j_reg;

    logic [uvs_pkg::ANG_W-1:0] aphi_q;
    logic [uvs_pkg::ANG_W-1:0] ath_q;
    logic [uvs_pkg::ANG_W-1:0] tu_q;
    logic [uvs_pkg::ANG_W-1:0] tv_q;

    uvs_pkg::late_t late_in;
    uvs_pkg::late_t late_d;
    uvs_pkg::late_t late_reg;

    logic signed [uvs_pkg::CORD_W-1:0] cos_phi;
    logic signed [uvs_pkg::CORD_W-1:0] sin_phi;
    logic signed [uvs_pkg::CORD_W-1:0] cos_th;
    logic signed [uvs_pkg::CORD_W-1:0] sin_th;
    logic signed [63:0]                mx_reg;
    logic signed [63:0]                mz_reg;
    logic signed [uvs_pkg::CORD_W-1:0] cy_reg;
    logic signed [63:0]                sx;
    logic signed [63:0]                sz;
    logic signed [63:0]                sy;

    logic        [15:0] f_x;
    logic        [15:0] f_y;
    logic        [15:0] f_z;
    logic        [15:0] f_u;
    logic        [15:0] f_v;
    logic        [15:0] f_a;
    logic        [15:0] f_b;
    logic        [15:0] f_c;
    logic               f_bad;

    logic               rsp_valid_reg;
    logic        [15:0] pos_x_reg;
    logic        [15:0] pos_y_reg;
    logic        [15:0] pos_z_reg;
    logic        [15:0] tex_u_reg;
    logic        [15:0] tex_v_reg;
    logic        [15:0] corner_a_reg;
    logic        [15:0] corner_b_reg;
    logic        [15:0] corner_c_reg;
    logic               bad_index_reg;

    assign adv = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slices_reg <= 9'd16;
            stacks_reg <= 9'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uvs_pkg::REG_SLICES: slices_reg <= cfg_data;
                uvs_pkg::REG_STACKS: stacks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (slices_reg < 9'd3)
        begin
            ns_next = NS_W'(3);
        end
        else if (int'(slices_reg) > MAX_SLICES)
        begin
            ns_next = NS_W'(MAX_SLICES);
        end
        else
        begin
            ns_next = NS_W'(slices_reg);
        end
        if (stacks_reg < 9'd2)
        begin
            nk_next = NK_W'(2);
        end
        else if (int'(stacks_reg) > MAX_STACKS)
        begin
            nk_next = NK_W'(MAX_STACKS);
        end
        else
        begin
            nk_next = NK_W'(stacks_reg);
        end
        m1 = CNT_W'(ns_next) * CNT_W'(nk_next - NK_W'(1));
        m2 = m1 - CNT_W'(ns_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_reg <= NS_W'(NS_RST);
            nk_reg <= NK_W'(NK_RST);
            nverts_reg <= CNT_W'(M1_RST + 2);
            ntris_reg <= CNT_W'(2 * M1_RST);
            body_reg <= CNT_W'(2 * M2_RST);
            last_reg <= CNT_W'(M2_RST + 1);
        end
        else
        begin
            ns_reg <= ns_next;
            nk_reg <= nk_next;
            nverts_reg <= m1 + CNT_W'(2);
            ntris_reg <= {m1[CNT_W-2:0], 1'b0};
            body_reg <= {m2[CNT_W-2:0], 1'b0};
            last_reg <= m2 + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd1_reg <= command;
            e1_reg <= element;
        end
    end

    always_comb
    begin
        e_x = CNT_W'(e1_reg);
        ns_x = CNT_W'(ns_reg);
        t_x = e_x - ns_x;
        i_x = t_x - body_reg;
        cap_c = (e_x + CNT_W'(1) == ns_x) ? CNT_W'(1) : e_x + CNT_W'(2);
        bot_n = (i_x + CNT_W'(1) == ns_x) ? '0 : i_x + CNT_W'(1);
        pre_next = '0;
        pre_next.valid = v1_reg;
        pre_next.kind = uvs_pkg::KIND_BAD;
        if (cmd1_reg == uvs_pkg::CMD_VERTEX)
        begin
            if (e_x >= nverts_reg)
            begin
                pre_next.kind = uvs_pkg::KIND_BAD;
            end
            else if (e_x == '0)
            begin
                pre_next.kind = uvs_pkg::KIND_TOP;
            end
            else if (e_x == nverts_reg - CNT_W'(1))
            begin
                pre_next.kind = uvs_pkg::KIND_BOT;
            end
            else
            begin
                pre_next.kind = uvs_pkg::KIND_VERT;
                pre_next.dividend = e1_reg - uvs_pkg::ELEM_W'(1);
            end
        end
        else
        begin
            if (e_x >= ntris_reg)
            begin
                pre_next.kind = uvs_pkg::KIND_BAD;
            end
            else if (e_x < ns_x)
            begin
                pre_next.kind = uvs_pkg::KIND_CAP;
                pre_next.b = 16'(e_x + CNT_W'(1));
                pre_next.c = cap_c[15:0];
            end
            else if (t_x < body_reg)
            begin
                pre_next.kind = uvs_pkg::KIND_BODY;
                pre_next.dividend = t_x[uvs_pkg::ELEM_W:1];
                pre_next.odd = t_x[0];
            end
            else
            begin
                pre_next.kind = uvs_pkg::KIND_CAP;
                pre_next.a = 16'(nverts_reg - CNT_W'(1));
                pre_next.b = 16'(last_reg + bot_n);
                pre_next.c = 16'(last_reg + i_x);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg <= '0;
        end
        else if (adv)
        begin
            pre_reg <= pre_next;
        end
    end

    uvs_divider #(
        .DW(NS_W),
        .QW(uvs_pkg::ELEM_W)
    ) u_div_ring (
        .clk (clk),
        .en  (adv),
        .num ((NS_W + uvs_pkg::ELEM_W)'(pre_reg.dividend)),
        .den (ns_reg),
        .quot(d1_quot),
        .rem (d1_rem)
    );

    uvs_delay #(
        .WIDTH($bits(uvs_pkg::pre_t)),
        .DEPTH(uvs_pkg::ELEM_W)
    ) u_dly_pre (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (adv),
        .d    (pre_reg),
        .q    (pre_d)
    );

    always_comb
    begin
        quad = CNT_W'(pre_d.dividend);
        i_b = CNT_W'(d1_rem);
        row0 = quad - i_b + CNT_W'(1);
        row1 = row0 + ns_x;
        nxt_b = (i_b + CNT_W'(1) == ns_x) ? '0 : i_b + CNT_W'(1);
        post_next.valid = pre_d.valid;
        post_next.kind = pre_d.kind;
        post_next.a = pre_d.a;
        post_next.b = pre_d.b;
        post_next.c = pre_d.c;
        if (pre_d.kind == uvs_pkg::KIND_BODY)
        begin
            post_next.a = 16'(quad + CNT_W'(1));
            if (!pre_d.odd)
            begin
                post_next.b = 16'(row1 + nxt_b);
                post_next.c = 16'(row0 + nxt_b);
            end
            else
            begin
                post_next.b = 16'(row1 + i_b);
                post_next.c = 16'(row1 + nxt_b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_reg <= '0;
        end
        else if (adv)
        begin
            post_reg <= post_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg <= d1_quot[NK_W-1:0] + NK_W'(1);
            j_reg <= d1_rem;
        end
    end

    uvs_divider #(
        .DW(NK_W + 1),
        .QW(uvs_pkg::ANG_W)
    ) u_div_phi (
        .clk (clk),
        .en  (adv),
        .num (PH_W'({r_reg, 32'd0}) + PH_W'(nk_reg)),
        .den ({nk_reg, 1'b0}),
        .quot(aphi_q),
        .rem ()
    );

    uvs_divider #(
        .DW(NS_W + 1),
        .QW(uvs_pkg::ANG_W)
    ) u_div_theta (
        .clk (clk),
        .en  (adv),
        .num (TH_W'({j_reg, 33'd0}) + TH_W'(ns_reg)),
        .den ({ns_reg, 1'b0}),
        .quot(ath_q),
        .rem ()
    );

    uvs_divider #(
        .DW(NS_W + 1),
        .QW(uvs_pkg::ANG_W)
    ) u_div_texu (
        .clk (clk),
        .en  (adv),
        .num (TH_W'({j_reg, 16'd0}) + TH_W'(ns_reg)),
        .den ({ns_reg, 1'b0}),
        .quot(tu_q),
        .rem ()
    );

    uvs_divider #(
        .DW(NK_W + 1),
        .QW(uvs_pkg::ANG_W)
    ) u_div_texv (
        .clk (clk),
        .en  (adv),
        .num (PH_W'({r_reg, 16'd0}) + PH_W'(nk_reg)),
        .den ({nk_reg, 1'b0}),
        .quot(tv_q),
        .rem ()
    );

    uvs_delay #(
        .WIDTH($bits(uvs_pkg::post_t)),
        .DEPTH(uvs_pkg::ANG_W)
    ) u_dly_post (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (adv),
        .d    (post_reg),
        .q    (post_d)
    );

    always_comb
    begin
        late_in.post = post_d;
        late_in.tex_u = uvs_pkg::TEX_ONE - tu_q[15:0];
        late_in.tex_v = uvs_pkg::TEX_ONE - tv_q[15:0];
    end

    uvs_delay #(
        .WIDTH($bits(uvs_pkg::late_t)),
        .DEPTH(CORDIC_STEPS + 1)
    ) u_dly_late (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (adv),
        .d    (late_in),
        .q    (late_d)
    );

    uvs_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic_phi (
        .clk    (clk),
        .en     (adv),
        .angle  (aphi_q),
        .cos_out(cos_phi),
        .sin_out(sin_phi)
    );

    uvs_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic_theta (
        .clk    (clk),
        .en     (adv),
        .angle  (ath_q),
        .cos_out(cos_th),
        .sin_out(sin_th)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            late_reg <= '0;
        end
        else if (adv)
        begin
            late_reg <= late_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg <= sin_phi * cos_th;
            mz_reg <= sin_phi * sin_th;
            cy_reg <= cos_phi;
        end
    end

    always_comb
    begin
        sx = (mx_reg + uvs_pkg::ROUND_46) >>> 46;
        sz = (mz_reg + uvs_pkg::ROUND_46) >>> 46;
        sy = (64'(cy_reg) + uvs_pkg::ROUND_16) >>> 16;
        f_x = '0;
        f_y = '0;
        f_z = '0;
        f_u = '0;
        f_v = '0;
        f_a = '0;
        f_b = '0;
        f_c = '0;
        f_bad = 1'b0;
        case (late_reg.post.kind)
            uvs_pkg::KIND_VERT:
            begin
                f_x = uvs_pkg::sat_q14(sx);
                f_y = uvs_pkg::sat_q14(sy);
                f_z = uvs_pkg::sat_q14(sz);
                f_u = late_reg.tex_u;
                f_v = late_reg.tex_v;
            end
            uvs_pkg::KIND_TOP:
            begin
                f_y = uvs_pkg::POS_ONE;
                f_v = uvs_pkg::TEX_ONE;
            end
            uvs_pkg::KIND_BOT:
            begin
                f_y = uvs_pkg::POS_MINUS_ONE;
            end
            uvs_pkg::KIND_CAP,
            uvs_pkg::KIND_BODY:
            begin
                f_a = late_reg.post.a;
                f_b = late_reg.post.b;
                f_c = late_reg.post.c;
            end
            uvs_pkg::KIND_BAD:
            begin
                f_bad = 1'b1;
            end
            default:
            begin
                f_bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= late_reg.post.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_x_reg <= f_x;
            pos_y_reg <= f_y;
            pos_z_reg <= f_z;
            tex_u_reg <= f_u;
            tex_v_reg <= f_v;
            corner_a_reg <= f_a;
            corner_b_reg <= f_b;
            corner_c_reg <= f_c;
            bad_index_reg <= f_bad;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;
    assign pos_z = pos_z_reg;
    assign tex_u = tex_u_reg;
    assign tex_v = tex_v_reg;
    assign corner_a = corner_a_reg;
    assign corner_b = corner_b_reg;
    assign corner_c = corner_c_reg;
    assign bad_index = bad_index_reg;

endmodule

`default_nettype wire

FILE: tb/uv_sphere_mesh_checker.sv
module uv_sphere_mesh_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        req_valid,
    input  wire logic        req_stall,
    input  wire logic        command,
    input  wire logic [16:0] element,
    input  wire logic        rsp_valid,
    input  wire logic        rsp_stall,
    input  wire logic [15:0] pos_x,
    input  wire logic [15:0] pos_y,
    input  wire logic [15:0] pos_z,
    input  wire logic [15:0] tex_u,
    input  wire logic [15:0] tex_v,
    input  wire logic [15:0] corner_a,
    input  wire logic [15:0] corner_b,
    input  wire logic [15:0] corner_c,
    input  wire logic        bad_index,
    output int               errors,
    output int               pending
);

    localparam int N_STEPS = 16;
    localparam int SLICE_CAP = 256;
    localparam int STACK_CAP = 256;

    typedef struct packed {
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] pz;
        logic [15:0] tu;
        logic [15:0] tv;
        logic [15:0] ca;
        logic [15:0] cb;
        logic [15:0] cc;
        logic        bad;
    } mesh_ans_t;

    logic [8:0] slice_reg;
    logic [8:0] stack_reg;
    mesh_ans_t  answers[$];

    assign pending = answers.size();

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    task automatic turn_sincos(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] sh;
        logic [1:0] quad;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        sh = ang + uvs_pkg::EIGHTH_TURN;
        quad = sh[31:30];
        z = longint'({2'b00, sh[29:0]}) - 64'sh2000_0000;
        x = 652032874;
        y = 0;
        for (int k = 0; k < N_STEPS && k < 24; k++)
        begin
            dx = shr_floor(y, k);
            dy = shr_floor(x, k);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(uvs_pkg::ATAN_TURNS[k]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(uvs_pkg::ATAN_TURNS[k]);
            end
        end
        case (quad)
            2'd0:
            begin
                c = x;
                s = y;
            end
            2'd1:
            begin
                c = -y;
                s = x;
            end
            2'd2:
            begin
                c = -x;
                s = -y;
            end
            default:
            begin
                c = y;
                s = -x;
            end
        endcase
    endtask

    function automatic logic [15:0] clamp_q14(longint v);
        if (v > 16384)
        begin
            return 16'h4000;
        end
        if (v < -16384)
        begin
            return 16'hC000;
        end
        return v[15:0];
    endfunction

    task automatic predict_element(input logic cmd, input logic [16:0] e, output mesh_ans_t r);
        longint ns;
        longint nk;
        longint nv;
        longint nt;
        longint k;
        longint ring;
        longint j;
        longint body;
        longint t;
        longint q;
        longint row0;
        longint row1;
        longint i;
        longint nx;
        longint a;
        longint b;
        longint c;
        logic [31:0] aphi;
        logic [31:0] ath;
        longint cp;
        longint sp;
        longint ct;
        longint st;
        ns = slice_reg;
        nk = stack_reg;
        if (ns < 3) ns = 3;
        if (ns > SLICE_CAP) ns = SLICE_CAP;
        if (nk < 2) nk = 2;
        if (nk > STACK_CAP) nk = STACK_CAP;
        nv = ns * (nk - 1) + 2;
        nt = 2 * ns * (nk - 1);
        r = '0;
        if (cmd == uvs_pkg::CMD_VERTEX)
        begin
            if (e >= nv)
            begin
                r.bad = 1'b1;
            end
            else if (e == 0)
            begin
                r.py = uvs_pkg::POS_ONE;
                r.tv = uvs_pkg::TEX_ONE;
            end
            else if (e == nv - 1)
            begin
                r.py = uvs_pkg::POS_MINUS_ONE;
            end
            else
            begin
                k = e - 1;
                ring = k / ns + 1;
                j = k % ns;
                aphi = 32'(((ring << 32) + nk) / (2 * nk));
                ath = 32'(((j << 33) + ns) / (2 * ns));
                turn_sincos(aphi, cp, sp);
                turn_sincos(ath, ct, st);
                r.px = clamp_q14(shr_floor(sp * ct + (64'sd1 <<< 45), 46));
                r.py = clamp_q14(shr_floor(cp + 32768, 16));
                r.pz = clamp_q14(shr_floor(sp * st + (64'sd1 <<< 45), 46));
                r.tu = 16'(32768 - (j * 65536 + ns) / (2 * ns));
                r.tv = 16'(32768 - (ring * 65536 + nk) / (2 * nk));
            end
        end
        else if (e >= nt)
        begin
            r.bad = 1'b1;
        end
        else
        begin
            body = 2 * ns * (nk - 2);
            if (e < ns)
            begin
                a = 0;
                b = e + 1;
                c = (e + 1) % ns + 1;
            end
            else if (e - ns < body)
            begin
                t = e - ns;
                q = t >> 1;
                row0 = (q / ns) * ns + 1;
                row1 = row0 + ns;
                i = q % ns;
                nx = (i + 1) % ns;
                a = row0 + i;
                if (t[0] == 1'b0)
                begin
                    b = row1 + nx;
                    c = row0 + nx;
                end
                else
                begin
                    b = row1 + i;
                    c = row1 + nx;
                end
            end
            else
            begin
                i = e - ns - body;
                row0 = ns * (nk - 2) + 1;
                a = nv - 1;
                b = row0 + (i + 1) % ns;
                c = row0 + i;
            end
            r.ca = a[15:0];
            r.cb = b[15:0];
            r.cc = c[15:0];
        end
    endtask

    task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mesh_ans_t p;
        mesh_ans_t got;
        if (!rst_n)
        begin
            slice_reg <= 9'd16;
            stack_reg <= 9'd16;
            answers.delete();
            errors = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predict_element(command, element, p);
                answers.insert(answers.size(), p);
            end
            if (rsp_valid && !rsp_stall)
            begin
                got = '{pos_x, pos_y, pos_z, tex_u, tex_v, corner_a, corner_b, corner_c,
                        bad_index};
                if (answers.size() == 0)
                begin
                    $error("response with no request outstanding");
                    errors++;
                end
                else
                begin
                    p = answers.pop_front();
                    compare_field("pos_x", p.px, got.px);
                    compare_field("pos_y", p.py, got.py);
                    compare_field("pos_z", p.pz, got.pz);
                    compare_field("tex_u", p.tu, got.tu);
                    compare_field("tex_v", p.tv, got.tv);
                    compare_field("corner_a", p.ca, got.ca);
                    compare_field("corner_b", p.cb, got.cb);
                    compare_field("corner_c", p.cc, got.cc);
                    compare_field("bad_index", 16'(p.bad), 16'(got.bad));
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == uvs_pkg::REG_SLICES)
                begin
                    slice_reg <= cfg_data;
                end
                else
                begin
                    stack_reg <= cfg_data;
                end
            end
        end
    end
endmodule

FILE: tb/uv_sphere_mesh_generator_top_tb.sv
module uv_sphere_mesh_generator_top_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 100;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [8:0]  cfg_data;
    logic        req_valid;
    logic        req_stall;
    logic        command;
    logic [16:0] element;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;
    logic        bad_index;
    int          errors;
    int          pending;
    int          idle_cycles;
    int          stall_mode;
    logic [8:0]  cur_slices;
    logic [8:0]  cur_stacks;

    uv_sphere_mesh_generator_top u_top (.*);

    uv_sphere_mesh_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
        end
    end

    task automatic write_reg(input logic idx, input logic [8:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(input logic cmd, input logic [16:0] e);
        req_valid <= 1'b1;
        command <= cmd;
        element <= e;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_pipeline;
        req_valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [8:0] ns, input logic [8:0] nk, input int count);
        int lim_s;
        int lim_k;
        int nv;
        int nt;
        int burst;
        int pick;
        logic [16:0] e;
        logic cmd;
        write_reg(uvs_pkg::REG_SLICES, ns);
        write_reg(uvs_pkg::REG_STACKS, nk);
        lim_s = (ns < 3) ? 3 : (ns > 256) ? 256 : ns;
        lim_k = (nk < 2) ? 2 : (nk > 256) ? 256 : nk;
        nv = lim_s * (lim_k - 1) + 2;
        nt = 2 * lim_s * (lim_k - 1);
        while (count > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && count > 0)
            begin
                cmd = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    e = 17'($urandom);
                end
                else if (pick == 1)
                begin
                    e = 17'(cmd ? nt : nv);
                end
                else if (pick == 2)
                begin
                    e = 17'(cmd ? nt - 1 : nv - 1);
                end
                else if (pick == 3)
                begin
                    e = 17'd0;
                end
                else
                begin
                    e = 17'($urandom_range(0, cmd ? nt - 1 : nv - 1));
                end
                send_request(cmd, e);
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        drain_pipeline();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 9'd0;
        req_valid = 1'b0;
        command = 1'b0;
        element = 17'd0;
        rsp_stall = 1'b0;
        stall_mode = 0;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_request(1'b0, 17'd0);
        send_request(1'b0, 17'd1);
        send_request(1'b0, 17'd8);
        send_request(1'b0, 17'd16);
        send_request(1'b0, 17'd121);
        send_request(1'b0, 17'd240);
        send_request(1'b0, 17'd241);
        send_request(1'b0, 17'd242);
        send_request(1'b0, 17'h1FFFF);
        send_request(1'b1, 17'd0);
        send_request(1'b1, 17'd15);
        send_request(1'b1, 17'd16);
        send_request(1'b1, 17'd17);
        send_request(1'b1, 17'd463);
        send_request(1'b1, 17'd464);
        send_request(1'b1, 17'd479);
        send_request(1'b1, 17'd480);
        send_request(1'b1, 17'h1FFFF);
        drain_pipeline();
        run_phase(9'd3, 9'd2, 150);
        run_phase(9'd256, 9'd256, 300);
        run_phase(9'd0, 9'd0, 100);
        run_phase(9'd511, 9'd511, 150);
        run_phase(9'd257, 9'd1, 100);
        for (int p = 0; p < 6; p++)
        begin
            cur_slices = 9'($urandom_range(0, 511));
            cur_stacks = 9'($urandom_range(0, 511));
            run_phase(cur_slices, cur_stacks, 190);
        end
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
